[hw/rtl/tspf_pkg.sv]
// Shared types and constants for the TCP SYN port filter.
// No dependencies; used by every module of the block but the checker.
package tspf_pkg;

    localparam int unsigned POS_W      = 7;
    localparam int unsigned OFF_W      = 8;
    localparam int unsigned CNT_W      = 64;
    localparam int unsigned PORT_W     = 16;
    localparam int unsigned M_TDATA_W  = 136;

    localparam logic [POS_W-1:0]  POS_MAX          = 7'd127;
    localparam logic [POS_W-1:0]  POS_ETYPE_HI     = 7'd12;
    localparam logic [POS_W-1:0]  POS_ETYPE_LO     = 7'd13;
    localparam logic [POS_W-1:0]  POS_IHL          = 7'd14;
    localparam logic [POS_W-1:0]  POS_PROTO        = 7'd23;
    localparam logic [POS_W-1:0]  POS_TCP_MIN      = 7'd16;
    localparam logic [OFF_W-1:0]  ETH_HDR_LEN      = 8'd14;
    localparam logic [OFF_W-1:0]  MIN_IP_FRAME     = 8'd34;
    localparam logic [OFF_W-1:0]  TCP_MIN_LEN      = 8'd20;
    localparam logic [OFF_W-1:0]  TCP_PORT_HI_OFF  = 8'd2;
    localparam logic [OFF_W-1:0]  TCP_PORT_LO_OFF  = 8'd3;
    localparam logic [OFF_W-1:0]  TCP_FLAGS_OFF    = 8'd13;
    localparam logic [15:0]       ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]        PROTO_TCP        = 8'd6;
    localparam logic [7:0]        FLAG_SYN         = 8'h02;
    localparam logic [7:0]        FLAG_ACK         = 8'h10;
    localparam logic [PORT_W-1:0] BLOCK_PORT_RESET = 16'd4040;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic last_byte;
        logic qualify;
        logic drop;
    } verdict_t;

endpackage

[hw/rtl/tspf_in_reg.sv]
// Input register of the TCP SYN port filter: holds one frame byte.
// Depends on tspf_pkg.
module tspf_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] frame_byte
    input  logic            s_tlast,    // last_byte
    input  logic            take,
    output logic            item_valid,
    output tspf_pkg::item_t item
);

    logic            valid_reg;
    tspf_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.frame_byte <= s_tdata;
            item_reg.last_byte  <= s_tlast;
        end
    end

endmodule

[hw/rtl/tspf_parse.sv]
// Header field capture and per-frame verdict of the TCP SYN port filter.
// Depends on tspf_pkg.
module tspf_parse (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  tspf_pkg::item_t               item,
    input  logic [tspf_pkg::PORT_W-1:0]   block_port,
    output tspf_pkg::verdict_t            verdict
);

    logic [tspf_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]                 etype_reg, etype_next;
    logic [3:0]                  hwords_reg, hwords_next;
    logic [7:0]                  proto_reg, proto_next;
    logic [15:0]                 dport_reg, dport_next;
    logic [7:0]                  flags_reg, flags_next;
    logic [tspf_pkg::OFF_W-1:0]  pos_w, frame_len, tcp_start;
    logic [7:0]                  b;
    logic                        qualify;

    assign b         = item.frame_byte;
    assign pos_w     = {1'b0, pos_reg};
    assign frame_len = pos_w + 8'd1;

    always_comb begin
        etype_next  = etype_reg;
        hwords_next = hwords_reg;
        proto_next  = proto_reg;
        dport_next  = dport_reg;
        flags_next  = flags_reg;

        if (pos_reg == tspf_pkg::POS_ETYPE_HI) begin
            etype_next[15:8] = b;
        end else if (pos_reg == tspf_pkg::POS_ETYPE_LO) begin
            etype_next[7:0] = b;
        end
        if (pos_reg == tspf_pkg::POS_IHL) begin
            hwords_next = b[3:0];
        end
        if (pos_reg == tspf_pkg::POS_PROTO) begin
            proto_next = b;
        end

        tcp_start = tspf_pkg::ETH_HDR_LEN + {2'b00, hwords_next, 2'b00};

        if (pos_reg >= tspf_pkg::POS_TCP_MIN && pos_reg < tspf_pkg::POS_MAX) begin
            if (pos_w == tcp_start + tspf_pkg::TCP_PORT_HI_OFF) begin
                dport_next[15:8] = b;
            end else if (pos_w == tcp_start + tspf_pkg::TCP_PORT_LO_OFF) begin
                dport_next[7:0] = b;
            end else if (pos_w == tcp_start + tspf_pkg::TCP_FLAGS_OFF) begin
                flags_next = b;
            end
        end

        pos_next = (pos_reg < tspf_pkg::POS_MAX) ? pos_reg + 7'd1 : pos_reg;

        qualify = (frame_len >= tspf_pkg::MIN_IP_FRAME)
               && (etype_next == tspf_pkg::ETHERTYPE_IPV4)
               && (proto_next == tspf_pkg::PROTO_TCP)
               && (frame_len >= tcp_start + tspf_pkg::TCP_MIN_LEN);

        verdict.last_byte = item.last_byte;
        verdict.qualify   = qualify;
        verdict.drop      = qualify
                         && (dport_next == block_port)
                         && ((flags_next & tspf_pkg::FLAG_SYN) != 8'd0)
                         && ((flags_next & tspf_pkg::FLAG_ACK) == 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            pos_reg    <= '0;
            etype_reg  <= '0;
            hwords_reg <= '0;
            proto_reg  <= '0;
            dport_reg  <= '0;
            flags_reg  <= '0;
        end else if (step) begin
            pos_reg    <= pos_next;
            etype_reg  <= etype_next;
            hwords_reg <= hwords_next;
            proto_reg  <= proto_next;
            dport_reg  <= dport_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

[hw/rtl/tspf_out_reg.sv]
// Frame counters and result register of the TCP SYN port filter.
// Depends on tspf_pkg.
module tspf_out_reg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  tspf_pkg::verdict_t               verdict,
    output logic                             out_free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tspf_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [tspf_pkg::CNT_W-1:0] tcp_total_reg, tcp_total_next;
    logic [tspf_pkg::CNT_W-1:0] drop_total_reg, drop_total_next;
    logic                       valid_reg;
    logic                       drop_reg;
    logic                       load;

    assign out_free = !valid_reg || m_tready;
    assign load     = step && verdict.last_byte;

    assign tcp_total_next  = tcp_total_reg + {{(tspf_pkg::CNT_W-1){1'b0}}, verdict.qualify};
    assign drop_total_next = drop_total_reg + {{(tspf_pkg::CNT_W-1){1'b0}}, verdict.drop};

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, drop_total_reg, tcp_total_reg, drop_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tcp_total_reg  <= '0;
            drop_total_reg <= '0;
        end else begin
            if (load) begin
                valid_reg      <= 1'b1;
                tcp_total_reg  <= tcp_total_next;
                drop_total_reg <= drop_total_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drop_reg <= verdict.drop;
        end
    end

endmodule

[hw/rtl/tcp_syn_port_filter_top.sv]
// TCP SYN port filter, top level.
// Frames enter one byte per item on the s_ channel, s_tlast on the final byte.
// One verdict item leaves on the m_ channel for every frame, after its final
// byte: drop flag plus the running 64-bit counts of IPv4 TCP frames and of
// dropped frames (both include the frame just judged, both wrap).
// A qualifying TCP frame whose destination port equals the configured port,
// with SYN set and ACK clear, is marked for drop.
// The verdict is registered in the result register when the final byte leaves the
// input register and the result register is free. Throughput: one byte per cycle,
// except that a final byte waits in the input register while the result register
// still holds a verdict that m_tready has not taken.
// The cfg channel writes the 16-bit blocked port; it is always ready. Write it
// only while no frame is in flight.
// Reset (aresetn low, synchronous): counters cleared, frame parse state
// cleared, blocked port back to 4040, both valid flags low.
// When m_tready is low the verdict holds; bytes that are not a final byte
// keep flowing, a second final byte waits in the input register.
// Depends on tspf_pkg, tspf_in_reg, tspf_parse, tspf_out_reg.
module tcp_syn_port_filter_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,    // [7:0] frame_byte
    input  logic           s_tlast,    // last_byte
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [135:0]   m_tdata,    // [0] drop_frame, [64:1] tcp_seen_count,
                                       // [128:65] dropped_count, [135:129] zero
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data    // [15:0] block_port
);

    logic                          item_valid;
    tspf_pkg::item_t               item;
    tspf_pkg::verdict_t            verdict;
    logic                          out_free;
    logic                          step;
    logic [tspf_pkg::PORT_W-1:0]   block_port_reg;

    assign cfg_ready = 1'b1;
    assign step      = item_valid && (!item.last_byte || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_port_reg <= tspf_pkg::BLOCK_PORT_RESET;
        end else if (cfg_valid) begin
            block_port_reg <= cfg_data;
        end
    end

    tspf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    tspf_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item),
        .block_port (block_port_reg),
        .verdict    (verdict)
    );

    tspf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .verdict  (verdict),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/tspf_checker.sv]
// Port-level checks for the TCP SYN port filter, bound to the top level.
// Depends on tcp_syn_port_filter_top ports only.
module tspf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         cfg_ready
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reset_ready_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind tcp_syn_port_filter_top tspf_checker u_tspf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

[verif/tb_tcp_syn_port_filter_top.sv]
`timescale 1ns / 100ps
// Testbench for tcp_syn_port_filter_top: byte-stream frames in, per-frame verdicts out,
// each verdict checked against an in-bench parser model. Depends on tspf_pkg and the RTL.
module tb_tcp_syn_port_filter_top;

    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86dd;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef struct {
        bit        drop;
        bit [63:0] seen;
        bit [63:0] dropped;
    } filter_verdict_t;

    logic           aclk = 1'b0;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;    // [7:0] frame_byte
    logic           s_tlast;    // last_byte
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;    // [0] drop_frame, [64:1] tcp_seen_count, [128:65] dropped_count
    logic           cfg_valid;
    logic           cfg_ready;
    logic [15:0]    cfg_data;   // [15:0] block_port

    tcp_syn_port_filter_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // parser model state
    bit [6:0]        pos_r;
    bit [15:0]       etype_r;
    bit [3:0]        ihl_r;
    bit [7:0]        proto_r;
    bit [15:0]       dport_r;
    bit [7:0]        flags_r;
    bit [63:0]       tcp_cnt;
    bit [63:0]       drop_cnt;
    bit [15:0]       port_cfg;
    filter_verdict_t verdict_q[$];

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned frames_sent;
    int unsigned port_writes;
    int unsigned burst_left;
    bit          gaps_on;
    int unsigned hold_left;
    logic [7:0]  frame_buf[$];

    task automatic track_byte(input logic [7:0] b, input logic last);
        int unsigned     pos;
        int unsigned     tcp_start;
        int unsigned     len;
        filter_verdict_t v;
        pos = pos_r;
        tcp_start = tspf_pkg::ETH_HDR_LEN + 4 * ihl_r;
        if (pos == tspf_pkg::POS_ETYPE_HI) begin
            etype_r[15:8] = b;
        end else if (pos == tspf_pkg::POS_ETYPE_LO) begin
            etype_r[7:0] = b;
        end
        if (pos == tspf_pkg::POS_IHL) begin
            ihl_r = b[3:0];
            tcp_start = tspf_pkg::ETH_HDR_LEN + 4 * ihl_r;
        end
        if (pos == tspf_pkg::POS_PROTO) begin
            proto_r = b;
        end
        if (pos >= tspf_pkg::POS_TCP_MIN && pos < tspf_pkg::POS_MAX) begin
            if (pos == tcp_start + tspf_pkg::TCP_PORT_HI_OFF) begin
                dport_r[15:8] = b;
            end else if (pos == tcp_start + tspf_pkg::TCP_PORT_LO_OFF) begin
                dport_r[7:0] = b;
            end else if (pos == tcp_start + tspf_pkg::TCP_FLAGS_OFF) begin
                flags_r = b;
            end
        end
        if (pos < tspf_pkg::POS_MAX) begin
            pos_r = 7'(pos + 1);
        end
        if (last) begin
            len = pos + 1;
            v.drop = 1'b0;
            if (len >= tspf_pkg::MIN_IP_FRAME && etype_r == tspf_pkg::ETHERTYPE_IPV4 &&
                proto_r == tspf_pkg::PROTO_TCP &&
                len >= tcp_start + tspf_pkg::TCP_MIN_LEN) begin
                tcp_cnt++;
                if (dport_r == port_cfg && (flags_r & tspf_pkg::FLAG_SYN) != 0 &&
                    (flags_r & tspf_pkg::FLAG_ACK) == 0) begin
                    v.drop = 1'b1;
                    drop_cnt++;
                end
            end
            v.seen = tcp_cnt;
            v.dropped = drop_cnt;
            verdict_q.push_back(v);
            pos_r = '0;
            etype_r = '0;
            ihl_r = '0;
            proto_r = '0;
            dport_r = '0;
            flags_r = '0;
            frames_sent++;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        track_byte(b, last);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_block_port(input logic [15:0] value);
        sender_idle();
        wait_drained();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        port_cfg = value;
        port_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random fill, then TCP fields, then Ethernet and IP header fields on top
    task automatic make_frame(input int unsigned len, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [15:0] port, input logic [7:0] flags);
        int unsigned tcp_start;
        tcp_start = tspf_pkg::ETH_HDR_LEN + 4 * ihl;
        frame_buf.delete();
        for (int i = 0; i < len; i++) begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (tcp_start + 2 < len) frame_buf[tcp_start + 2] = port[15:8];
        if (tcp_start + 3 < len) frame_buf[tcp_start + 3] = port[7:0];
        if (tcp_start + 13 < len) frame_buf[tcp_start + 13] = flags;
        if (len > 12) frame_buf[12] = etype[15:8];
        if (len > 13) frame_buf[13] = etype[7:0];
        if (len > 14) frame_buf[14] = {4'($urandom_range(0, 15)), ihl};
        if (len > 23) frame_buf[23] = proto;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            send_item(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    task automatic send_tcp(input int unsigned len, input logic [3:0] ihl,
                            input logic [15:0] port, input logic [7:0] flags);
        make_frame(len, tspf_pkg::ETHERTYPE_IPV4, ihl, tspf_pkg::PROTO_TCP, port, flags);
        send_frame();
    endtask

    task automatic test_directed_frames();
        send_tcp(54, 5, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_tcp(54, 5, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN | tspf_pkg::FLAG_ACK);
        send_tcp(60, 5, 16'(tspf_pkg::BLOCK_PORT_RESET + 1), tspf_pkg::FLAG_SYN);
        send_tcp(54, 5, tspf_pkg::BLOCK_PORT_RESET, 8'h00);
        make_frame(54, ETHERTYPE_IPV6, 5, tspf_pkg::PROTO_TCP, tspf_pkg::BLOCK_PORT_RESET,
                   tspf_pkg::FLAG_SYN);
        send_frame();
        make_frame(54, tspf_pkg::ETHERTYPE_IPV4, 5, PROTO_UDP, tspf_pkg::BLOCK_PORT_RESET,
                   tspf_pkg::FLAG_SYN);
        send_frame();
        // too short for Ethernet plus IP, then TCP header cut by one byte
        send_tcp(33, 0, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_tcp(53, 5, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b1);
        // header length below five overlaps TCP with IP
        send_tcp(34, 0, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_tcp(38, 1, tspf_pkg::BLOCK_PORT_RESET, 8'hff & ~tspf_pkg::FLAG_ACK);
        // long frames: longest IP header, then past the position limit
        send_tcp(94, 15, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_tcp(130, 15, tspf_pkg::BLOCK_PORT_RESET, tspf_pkg::FLAG_SYN);
        send_tcp(130, 5, tspf_pkg::BLOCK_PORT_RESET, 8'hff);
        frame_buf.delete();
        for (int i = 0; i < 60; i++) frame_buf.push_back(8'hff);
        send_frame();
        frame_buf.delete();
        for (int i = 0; i < 60; i++) frame_buf.push_back(8'h00);
        send_frame();
    endtask

    task automatic test_block_port_sweep();
        logic [15:0] ports[3];
        ports[0] = 16'h0000;
        ports[1] = 16'hffff;
        ports[2] = 16'($urandom_range(0, 65535));
        foreach (ports[k]) begin
            write_block_port(ports[k]);
            send_tcp(54, 5, ports[k], tspf_pkg::FLAG_SYN);
            send_tcp(58, 6, ports[k] ^ 16'h0001, tspf_pkg::FLAG_SYN);
            send_tcp(54, 5, ports[k], tspf_pkg::FLAG_SYN | tspf_pkg::FLAG_ACK);
            send_tcp(54, 5, ports[k], 8'($urandom_range(0, 255)));
        end
        write_block_port(tspf_pkg::BLOCK_PORT_RESET);
    endtask

    task automatic test_backpressure();
        sender_idle();
        @(posedge aclk);
        hold_left = 300;
        gaps_on = 1'b0;
        for (int i = 0; i < 40; i++) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        repeat (3) send_tcp(54, 5, port_cfg, tspf_pkg::FLAG_SYN);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned start_frames;
        int unsigned roll;
        int unsigned sel;
        int unsigned len;
        int unsigned tcp_start;
        logic [3:0]  ihl;
        logic [15:0] port;
        logic [7:0]  flags;
        logic [15:0] etype;
        logic [7:0]  proto;
        start_frames = frames_sent;
        while (bytes_sent < 1950 || frames_sent - start_frames < 4) begin
            if ((frames_sent - start_frames) % 4 == 3) begin
                sel = $urandom_range(0, 3);
                write_block_port(sel == 0 ? 16'h0000 : sel == 1 ? 16'hffff :
                                 16'($urandom_range(0, 65535)));
                gaps_on = $urandom_range(0, 2) != 0;
            end
            roll = $urandom_range(0, 99);
            ihl = $urandom_range(0, 99) < 80 ? 4'd5 : 4'($urandom_range(0, 15));
            tcp_start = tspf_pkg::ETH_HDR_LEN + 4 * ihl;
            port = $urandom_range(0, 99) < 60 ? port_cfg : 16'($urandom_range(0, 65535));
            flags = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
                flags = (flags | tspf_pkg::FLAG_SYN) & ~tspf_pkg::FLAG_ACK;
            end
            etype = tspf_pkg::ETHERTYPE_IPV4;
            proto = tspf_pkg::PROTO_TCP;
            len = tcp_start + tspf_pkg::TCP_MIN_LEN + $urandom_range(0, 12);
            if ($urandom_range(0, 19) == 0) len = $urandom_range(128, 180);
            if (len < tspf_pkg::MIN_IP_FRAME) len = tspf_pkg::MIN_IP_FRAME + $urandom_range(0, 4);
            if (roll >= 70 && roll < 80) begin
                len = $urandom_range(1, tcp_start + tspf_pkg::TCP_MIN_LEN - 1);
            end else if (roll >= 80 && roll < 88) begin
                etype = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) :
                        tspf_pkg::ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15));
            end else if (roll >= 88 && roll < 94) begin
                proto = tspf_pkg::PROTO_TCP ^ 8'(1 << $urandom_range(0, 7));
            end
            if (roll >= 94) begin
                frame_buf.delete();
                len = $urandom_range(1, 40);
                for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                make_frame(len, etype, ihl, proto, port, flags);
            end
            send_frame();
        end
        gaps_on = 1'b1;
    endtask

    // receiver readiness: switch stall pattern now and then, honor long hold-offs
    initial begin : rx_ready_gen
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        m_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = $urandom_range(0, 3) != 0;
                    2: m_tready = tick[2:0] != 3'b101 && tick[2:0] != 3'b110;
                    default: m_tready = $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        filter_verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected verdict item, m_tdata %h", m_tdata);
                error_count++;
            end else begin
                v = verdict_q.pop_front();
                if (m_tdata[0] !== v.drop) begin
                    $error("drop_frame: expected %0d, actual %0d", v.drop, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[64:1] !== v.seen) begin
                    $error("tcp_seen_count: expected %0d, actual %0d", v.seen, m_tdata[64:1]);
                    error_count++;
                end
                if (m_tdata[128:65] !== v.dropped) begin
                    $error("dropped_count: expected %0d, actual %0d", v.dropped,
                           m_tdata[128:65]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #800000;
        $display("timeout with %0d verdicts outstanding", verdict_q.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pos_r = '0;
        etype_r = '0;
        ihl_r = '0;
        proto_r = '0;
        dport_r = '0;
        flags_r = '0;
        tcp_cnt = '0;
        drop_cnt = '0;
        port_cfg = tspf_pkg::BLOCK_PORT_RESET;
        error_count = 0;
        bytes_sent = 0;
        frames_sent = 0;
        port_writes = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_left = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_frames();
        test_block_port_sweep();
        test_backpressure();
        test_random_traffic();

        sender_idle();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            $error("verdicts never arrived: %0d", verdict_q.size());
            error_count++;
        end
        $display("sent %0d bytes in %0d frames over %0d drop port settings",
                 bytes_sent, frames_sent, port_writes + 1);
        $display("model counted %0d IPv4 TCP frames, %0d dropped, %0d mismatches",
                 tcp_cnt, drop_cnt, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[tcp_syn_port_filter_top.f]
hw/rtl/tspf_pkg.sv
hw/rtl/tspf_in_reg.sv
hw/rtl/tspf_parse.sv
hw/rtl/tspf_out_reg.sv
hw/rtl/tcp_syn_port_filter_top.sv
hw/rtl/tspf_checker.sv
verif/tb_tcp_syn_port_filter_top.sv
